>>> rtl/packed_link_table_insert_remove_unit_defines.svh
// Assertion shorthands for the RTL datapath.
`ifndef PACKED_LINK_TABLE_INSERT_REMOVE_UNIT_DEFINES_SVH
`define PACKED_LINK_TABLE_INSERT_REMOVE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define PLTIR_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define PLTIR_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/pltir_pkg.sv
`default_nettype none
package pltir_pkg;

  localparam int TOTW   = 13;
  localparam int IDXW   = 12;
  localparam int FLW    = 12;
  localparam int CNTW   = 4;
  localparam int SIDEW  = 4;
  localparam int EDGEW  = 2;
  localparam int TGTW   = 10;
  localparam int TRICFW = 11;
  localparam int ENTW   = 16;
  localparam logic [CNTW-1:0] CNT_MAX = 4'd15;

  typedef enum logic [2:0] {
    CMD_LOAD_TRI, CMD_APPEND, CMD_ADD, CMD_UPDATE,
    CMD_REMOVE, CMD_READ_TRI, CMD_READ_LINK, CMD_CLEAR
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK, ST_BAD_INDEX, ST_EXISTS, ST_NO_LINK, ST_FULL, ST_OVERFLOW
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_TRI_CHK, S_HEAD_RD, S_HEAD_CHK, S_ADD_SH, S_ADD_WR,
    S_RM_SH, S_RM_WR, S_ADJ_RD, S_ADJ_WR, S_RD_TRI, S_RD_LINK, S_FIN
  } state_t;

  typedef enum logic {TA_IDX, TA_PTR} tri_asel_t;
  typedef enum logic [1:0] {TW_LOAD, TW_OWN_INC, TW_OWN_DEC, TW_ADJ} tri_wsel_t;
  typedef enum logic [1:0] {LR_IDX, LR_HEAD, LR_PTR_DN, LR_PTR_UP} lk_rsel_t;
  typedef enum logic [1:0] {LW_TOTAL, LW_HEAD, LW_PTR} lk_wasel_t;
  typedef enum logic [1:0] {LD_APPEND, LD_SPECIAL, LD_UPDATE, LD_COPY} lk_dsel_t;
  typedef enum logic [1:0] {TOT_HOLD, TOT_INC, TOT_DEC, TOT_CLR} tot_op_t;
  typedef enum logic [2:0] {LP_HOLD, LP_LOAD_TOTAL, LP_LOAD_HEAD, LP_INC, LP_DEC} lptr_op_t;

  typedef struct packed {
    logic      in_ready;
    logic      latch_in;
    logic      st_load;
    status_t   st_code;
    logic      tri_re;
    logic      tri_we;
    tri_asel_t tri_asel;
    tri_wsel_t tri_wsel;
    logic      tri_grab;
    logic      lk_re;
    lk_rsel_t  lk_rsel;
    logic      lk_we;
    lk_wasel_t lk_wasel;
    lk_dsel_t  lk_dsel;
    tot_op_t   tot_op;
    lptr_op_t  lptr_op;
    logic      tptr_load;
    logic      tptr_inc;
    logic      grab_rd_tri;
    logic      grab_rd_lk;
    logic      res_load;
  } ctl_t;

  typedef struct packed {
    cmd_t cmd;
    logic idx_lt_max_tri;
    logic idx_lt_inuse;
    logic idx_lt_total;
    logic total_full;
    logic head_special;
    logic f_gt_total;
    logic count_zero;
    logic count_max;
    logic add_done;
    logic rm_done;
    logic adj_done;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

>>> rtl/packed_link_table_insert_remove_unit.sv
// Packed link table with special-link insert and remove. One request in,
// one result out, one request in flight at a time; a finished result is held
// in an output register so the next request may be accepted while it waits.
// Load, append, clear, update, read and out-of-range cases run no loop. Add
// and remove shift each moved link with a read and a write, then rewrite the
// first-link field of each later triangle in use with a read and a write; the
// link and triangle RAMs each have one write port and one registered read
// port. The tables come up undefined and need no clearing pass; reset clears
// the link total, output valid and triangle count, and sets the special side to 15.
`default_nettype none
module packed_link_table_insert_remove_unit
  import pltir_pkg::*;
#(
  parameter int MAX_TRIANGLES = 1024,
  parameter int MAX_LINKS     = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [2:0]        cmd,
  input  wire logic [IDXW-1:0]   index,
  input  wire logic [FLW-1:0]    first_link_in,
  input  wire logic [CNTW-1:0]   link_count_in,
  input  wire logic [SIDEW-1:0]  side_in,
  input  wire logic [EDGEW-1:0]  edge_in,
  input  wire logic [TGTW-1:0]   target_in,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [2:0]             status,
  output logic [FLW-1:0]         first_link_out,
  output logic [CNTW-1:0]        link_count_out,
  output logic [SIDEW-1:0]       side_out,
  output logic [EDGEW-1:0]       edge_out,
  output logic [TGTW-1:0]        target_out,
  output logic [TOTW-1:0]        total_links_out
);

  logic [TRICFW-1:0] triangle_count;
  logic [SIDEW-1:0]  special_side_code;
  ctl_t              ctl;
  sts_t              sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      triangle_count    <= '0;
      special_side_code <= 4'd15;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        special_side_code <= pwdata[SIDEW-1:0];
      end else begin
        triangle_count <= pwdata[TRICFW-1:0];
      end
    end
  end

  assign prdata = paddr[2] ? {28'b0, special_side_code} : {21'b0, triangle_count};
  assign in_stall = !ctl.in_ready;

  pltir_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sts      (sts),
    .ctl      (ctl)
  );

  pltir_dp #(
    .MAX_TRIANGLES (MAX_TRIANGLES),
    .MAX_LINKS     (MAX_LINKS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .sts             (sts),
    .tri_cnt_cfg     (triangle_count),
    .special_side    (special_side_code),
    .cmd             (cmd),
    .index           (index),
    .first_link_in   (first_link_in),
    .link_count_in   (link_count_in),
    .side_in         (side_in),
    .edge_in         (edge_in),
    .target_in       (target_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .first_link_out  (first_link_out),
    .link_count_out  (link_count_out),
    .side_out        (side_out),
    .edge_out        (edge_out),
    .target_out      (target_out),
    .total_links_out (total_links_out)
  );

endmodule
`default_nettype wire

>>> rtl/pltir_ram.sv
`default_nettype none
module pltir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/pltir_ctrl.sv
`default_nettype none
module pltir_ctrl
  import pltir_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire sts_t sts,
  output ctl_t      ctl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    ctl = '0;
    state_next = state;
    ctl.in_ready = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.latch_in = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_FIN;
        case (sts.cmd)
          CMD_LOAD_TRI: begin
            if (!sts.idx_lt_max_tri) begin
              ctl.st_load = 1'b1;
              ctl.st_code = ST_BAD_INDEX;
            end else begin
              ctl.tri_we = 1'b1;
              ctl.tri_asel = TA_IDX;
              ctl.tri_wsel = TW_LOAD;
            end
          end
          CMD_APPEND: begin
            if (sts.total_full) begin
              ctl.st_load = 1'b1;
              ctl.st_code = ST_FULL;
            end else begin
              ctl.lk_we = 1'b1;
              ctl.lk_wasel = LW_TOTAL;
              ctl.lk_dsel = LD_APPEND;
              ctl.tot_op = TOT_INC;
            end
          end
          CMD_ADD, CMD_UPDATE, CMD_REMOVE: begin
            if (!sts.idx_lt_inuse) begin
              ctl.st_load = 1'b1;
              ctl.st_code = ST_BAD_INDEX;
            end else begin
              ctl.tri_re = 1'b1;
              ctl.tri_asel = TA_IDX;
              state_next = S_TRI_CHK;
            end
          end
          CMD_READ_TRI: begin
            if (!sts.idx_lt_max_tri) begin
              ctl.st_load = 1'b1;
              ctl.st_code = ST_BAD_INDEX;
            end else begin
              ctl.tri_re = 1'b1;
              ctl.tri_asel = TA_IDX;
              state_next = S_RD_TRI;
            end
          end
          CMD_READ_LINK: begin
            if (!sts.idx_lt_total) begin
              ctl.st_load = 1'b1;
              ctl.st_code = ST_BAD_INDEX;
            end else begin
              ctl.lk_re = 1'b1;
              ctl.lk_rsel = LR_IDX;
              state_next = S_RD_LINK;
            end
          end
          default: begin
            ctl.tot_op = TOT_CLR;
          end
        endcase
      end
      S_TRI_CHK: begin
        ctl.tri_grab = 1'b1;
        state_next = S_HEAD_RD;
      end
      S_HEAD_RD: begin
        ctl.lk_re = 1'b1;
        ctl.lk_rsel = LR_HEAD;
        state_next = S_HEAD_CHK;
      end
      S_HEAD_CHK: begin
        state_next = S_FIN;
        case (sts.cmd)
          CMD_ADD: begin
            if (!sts.count_zero && sts.head_special) begin
              ctl.st_load = 1'b1;
              ctl.st_code = ST_EXISTS;
            end else if (sts.f_gt_total) begin
              ctl.st_load = 1'b1;
              ctl.st_code = ST_BAD_INDEX;
            end else if (sts.count_max) begin
              ctl.st_load = 1'b1;
              ctl.st_code = ST_OVERFLOW;
            end else if (sts.total_full) begin
              ctl.st_load = 1'b1;
              ctl.st_code = ST_FULL;
            end else begin
              ctl.lptr_op = LP_LOAD_TOTAL;
              state_next = S_ADD_SH;
            end
          end
          CMD_UPDATE: begin
            if (!sts.head_special) begin
              ctl.st_load = 1'b1;
              ctl.st_code = ST_NO_LINK;
            end else begin
              ctl.lk_we = 1'b1;
              ctl.lk_wasel = LW_HEAD;
              ctl.lk_dsel = LD_UPDATE;
            end
          end
          default: begin
            if (sts.count_zero || !sts.head_special) begin
              ctl.st_load = 1'b1;
              ctl.st_code = ST_NO_LINK;
            end else begin
              ctl.lptr_op = LP_LOAD_HEAD;
              state_next = S_RM_SH;
            end
          end
        endcase
      end
      S_ADD_SH: begin
        if (sts.add_done) begin
          ctl.lk_we = 1'b1;
          ctl.lk_wasel = LW_HEAD;
          ctl.lk_dsel = LD_SPECIAL;
          ctl.tot_op = TOT_INC;
          ctl.tri_we = 1'b1;
          ctl.tri_asel = TA_IDX;
          ctl.tri_wsel = TW_OWN_INC;
          ctl.tptr_load = 1'b1;
          state_next = S_ADJ_RD;
        end else begin
          ctl.lk_re = 1'b1;
          ctl.lk_rsel = LR_PTR_DN;
          state_next = S_ADD_WR;
        end
      end
      S_ADD_WR: begin
        ctl.lk_we = 1'b1;
        ctl.lk_wasel = LW_PTR;
        ctl.lk_dsel = LD_COPY;
        ctl.lptr_op = LP_DEC;
        state_next = S_ADD_SH;
      end
      S_RM_SH: begin
        if (sts.rm_done) begin
          ctl.tot_op = TOT_DEC;
          ctl.tri_we = 1'b1;
          ctl.tri_asel = TA_IDX;
          ctl.tri_wsel = TW_OWN_DEC;
          ctl.tptr_load = 1'b1;
          state_next = S_ADJ_RD;
        end else begin
          ctl.lk_re = 1'b1;
          ctl.lk_rsel = LR_PTR_UP;
          state_next = S_RM_WR;
        end
      end
      S_RM_WR: begin
        ctl.lk_we = 1'b1;
        ctl.lk_wasel = LW_PTR;
        ctl.lk_dsel = LD_COPY;
        ctl.lptr_op = LP_INC;
        state_next = S_RM_SH;
      end
      S_ADJ_RD: begin
        if (sts.adj_done) begin
          state_next = S_FIN;
        end else begin
          ctl.tri_re = 1'b1;
          ctl.tri_asel = TA_PTR;
          state_next = S_ADJ_WR;
        end
      end
      S_ADJ_WR: begin
        ctl.tri_we = 1'b1;
        ctl.tri_asel = TA_PTR;
        ctl.tri_wsel = TW_ADJ;
        ctl.tptr_inc = 1'b1;
        state_next = S_ADJ_RD;
      end
      S_RD_TRI: begin
        ctl.grab_rd_tri = 1'b1;
        state_next = S_FIN;
      end
      S_RD_LINK: begin
        ctl.grab_rd_lk = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          ctl.res_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/pltir_dp.sv
`default_nettype none
`include "packed_link_table_insert_remove_unit_defines.svh"
module pltir_dp
  import pltir_pkg::*;
#(
  parameter int MAX_TRIANGLES = 1024,
  parameter int MAX_LINKS     = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ctl_t              ctl,
  output sts_t                   sts,
  input  wire logic [TRICFW-1:0] tri_cnt_cfg,
  input  wire logic [SIDEW-1:0]  special_side,
  input  wire logic [2:0]        cmd,
  input  wire logic [IDXW-1:0]   index,
  input  wire logic [FLW-1:0]    first_link_in,
  input  wire logic [CNTW-1:0]   link_count_in,
  input  wire logic [SIDEW-1:0]  side_in,
  input  wire logic [EDGEW-1:0]  edge_in,
  input  wire logic [TGTW-1:0]   target_in,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [2:0]             status,
  output logic [FLW-1:0]         first_link_out,
  output logic [CNTW-1:0]        link_count_out,
  output logic [SIDEW-1:0]       side_out,
  output logic [EDGEW-1:0]       edge_out,
  output logic [TGTW-1:0]        target_out,
  output logic [TOTW-1:0]        total_links_out
);

  localparam int TAW = $clog2(MAX_TRIANGLES);
  localparam int LAW = $clog2(MAX_LINKS);
  localparam int TPW = TAW + 1;
  localparam int LPW = LAW + 1;

  cmd_t             cmd_r;
  logic [IDXW-1:0]  idx_r;
  logic [FLW-1:0]   fin_r;
  logic [CNTW-1:0]  cin_r;
  logic [SIDEW-1:0] side_r;
  logic [EDGEW-1:0] edge_r;
  logic [TGTW-1:0]  tgt_r;
  logic [TOTW-1:0]  total;
  logic [FLW-1:0]   tri_first;
  logic [CNTW-1:0]  tri_cnt;
  logic [LPW-1:0]   lptr;
  logic [TPW-1:0]   tptr;
  status_t          st;
  logic [FLW-1:0]   rf;
  logic [CNTW-1:0]  rc;
  logic [SIDEW-1:0] rs;
  logic [EDGEW-1:0] re;
  logic [TGTW-1:0]  rt;

  logic [TOTW-1:0]  inuse_w;
  logic [TPW-1:0]   inuse;
  logic [LPW-1:0]   lptr_dn, lptr_up;
  logic [FLW-1:0]   adj_first;

  logic [TAW-1:0]   tri_addr;
  logic [ENTW-1:0]  tri_wdata, tri_rdata;
  logic [LAW-1:0]   lk_raddr, lk_waddr;
  logic [ENTW-1:0]  lk_wdata, lk_rdata;

  assign inuse_w = (TOTW'(tri_cnt_cfg) > TOTW'(MAX_TRIANGLES)) ?
                   TOTW'(MAX_TRIANGLES) : TOTW'(tri_cnt_cfg);
  assign inuse   = inuse_w[TPW-1:0];
  assign lptr_dn = lptr - LPW'(1);
  assign lptr_up = lptr + LPW'(1);
  assign adj_first = (cmd_r == CMD_ADD) ? tri_rdata[15:4] + FLW'(1)
                                        : tri_rdata[15:4] - FLW'(1);

  always_comb begin
    sts.cmd            = cmd_r;
    sts.idx_lt_max_tri = TOTW'(idx_r) < TOTW'(MAX_TRIANGLES);
    sts.idx_lt_inuse   = TOTW'(idx_r) < TOTW'(inuse);
    sts.idx_lt_total   = TOTW'(idx_r) < total;
    sts.total_full     = total >= TOTW'(MAX_LINKS);
    sts.head_special   = (TOTW'(tri_first) < total) && (lk_rdata[15:12] == special_side);
    sts.f_gt_total     = TOTW'(tri_first) > total;
    sts.count_zero     = tri_cnt == '0;
    sts.count_max      = tri_cnt == CNT_MAX;
    sts.add_done       = TOTW'(lptr) == TOTW'(tri_first);
    sts.rm_done        = TOTW'(lptr) + TOTW'(1) >= total;
    sts.adj_done       = tptr >= inuse;
    sts.out_free       = !out_valid || !out_stall;
  end

  always_comb begin
    tri_addr = (ctl.tri_asel == TA_PTR) ? tptr[TAW-1:0] : idx_r[TAW-1:0];
    case (ctl.tri_wsel)
      TW_LOAD:    tri_wdata = {fin_r, cin_r};
      TW_OWN_INC: tri_wdata = {tri_first, tri_cnt + CNTW'(1)};
      TW_OWN_DEC: tri_wdata = {tri_first, tri_cnt - CNTW'(1)};
      default:    tri_wdata = {adj_first, tri_rdata[3:0]};
    endcase
    case (ctl.lk_rsel)
      LR_IDX:    lk_raddr = idx_r[LAW-1:0];
      LR_HEAD:   lk_raddr = tri_first[LAW-1:0];
      LR_PTR_DN: lk_raddr = lptr_dn[LAW-1:0];
      default:   lk_raddr = lptr_up[LAW-1:0];
    endcase
    case (ctl.lk_wasel)
      LW_TOTAL: lk_waddr = total[LAW-1:0];
      LW_HEAD:  lk_waddr = tri_first[LAW-1:0];
      default:  lk_waddr = lptr[LAW-1:0];
    endcase
    case (ctl.lk_dsel)
      LD_APPEND:  lk_wdata = {side_r, edge_r, tgt_r};
      LD_SPECIAL: lk_wdata = {special_side, 2'b00, tgt_r};
      LD_UPDATE:  lk_wdata = {lk_rdata[15:10], tgt_r};
      default:    lk_wdata = lk_rdata;
    endcase
  end

  pltir_ram #(.WIDTH(ENTW), .DEPTH(MAX_TRIANGLES)) u_tri_ram (
    .clk   (clk),
    .we    (ctl.tri_we),
    .waddr (tri_addr),
    .wdata (tri_wdata),
    .re    (ctl.tri_re),
    .raddr (tri_addr),
    .rdata (tri_rdata)
  );

  pltir_ram #(.WIDTH(ENTW), .DEPTH(MAX_LINKS)) u_link_ram (
    .clk   (clk),
    .we    (ctl.lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .re    (ctl.lk_re),
    .raddr (lk_raddr),
    .rdata (lk_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      case (ctl.tot_op)
        TOT_INC: total <= total + TOTW'(1);
        TOT_DEC: total <= total - TOTW'(1);
        TOT_CLR: total <= '0;
        default: total <= total;
      endcase
      if (ctl.res_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request and working registers
  always_ff @(posedge clk) begin
    if (ctl.latch_in) begin
      cmd_r  <= cmd_t'(cmd);
      idx_r  <= index;
      fin_r  <= first_link_in;
      cin_r  <= link_count_in;
      side_r <= side_in;
      edge_r <= edge_in;
      tgt_r  <= target_in;
      st     <= ST_OK;
      rf     <= '0;
      rc     <= '0;
      rs     <= '0;
      re     <= '0;
      rt     <= '0;
    end
    if (ctl.st_load) begin
      st <= ctl.st_code;
    end
    if (ctl.tri_grab) begin
      tri_first <= tri_rdata[15:4];
      tri_cnt   <= tri_rdata[3:0];
    end
    if (ctl.grab_rd_tri) begin
      rf <= tri_rdata[15:4];
      rc <= tri_rdata[3:0];
    end
    if (ctl.grab_rd_lk) begin
      rs <= lk_rdata[15:12];
      re <= lk_rdata[11:10];
      rt <= lk_rdata[9:0];
    end
    case (ctl.lptr_op)
      LP_LOAD_TOTAL: lptr <= total[LPW-1:0];
      LP_LOAD_HEAD:  lptr <= LPW'(tri_first);
      LP_INC:        lptr <= lptr_up;
      LP_DEC:        lptr <= lptr_dn;
      default:       lptr <= lptr;
    endcase
    if (ctl.tptr_load) begin
      tptr <= TPW'(idx_r[TAW-1:0]) + TPW'(1);
    end else if (ctl.tptr_inc) begin
      tptr <= tptr + TPW'(1);
    end
    if (ctl.res_load) begin
      status          <= st;
      first_link_out  <= rf;
      link_count_out  <= rc;
      side_out        <= rs;
      edge_out        <= re;
      target_out      <= rt;
      total_links_out <= total;
    end
  end

  `PLTIR_CHECK(a_total_bound, 1'b1, total <= TOTW'(MAX_LINKS), "link total above table size")
  `PLTIR_CHECK(a_append_room, ctl.lk_we && ctl.lk_wasel == LW_TOTAL, total < TOTW'(MAX_LINKS), "append into full table")
  `PLTIR_CHECK(a_head_in_run, ctl.lk_we && ctl.lk_wasel == LW_HEAD, TOTW'(tri_first) <= total, "head write beyond link run")
  `PLTIR_NEXT(a_shift_dec, ctl.lptr_op == LP_DEC, TOTW'(lptr) >= TOTW'(tri_first), "insert shift passed head")

endmodule
`default_nettype wire

>>> verif/link_table_checker.sv
module link_table_checker
  import pltir_pkg::*;
#(
  parameter int ADDR_TRI_COUNT    = 0,
  parameter int ADDR_SPECIAL_SIDE = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic             pready,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [2:0]       cmd,
  input  logic [IDXW-1:0]  index,
  input  logic [FLW-1:0]   first_link_in,
  input  logic [CNTW-1:0]  link_count_in,
  input  logic [SIDEW-1:0] side_in,
  input  logic [EDGEW-1:0] edge_in,
  input  logic [TGTW-1:0]  target_in,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [2:0]       status,
  input  logic [FLW-1:0]   first_link_out,
  input  logic [CNTW-1:0]  link_count_out,
  input  logic [SIDEW-1:0] side_out,
  input  logic [EDGEW-1:0] edge_out,
  input  logic [TGTW-1:0]  target_out,
  input  logic [TOTW-1:0]  total_links_out,
  output int               pending,
  output int               errors
);

  localparam int NTRI  = 1024;
  localparam int NLINK = 4096;

  typedef struct packed {
    status_t          st;
    logic [FLW-1:0]   fl;
    logic [CNTW-1:0]  lc;
    logic [SIDEW-1:0] sd;
    logic [EDGEW-1:0] ed;
    logic [TGTW-1:0]  tg;
    logic [TOTW-1:0]  tot;
  } link_result_t;

  logic [FLW-1:0]   tri_first [NTRI];
  logic [CNTW-1:0]  tri_cnt   [NTRI];
  logic [SIDEW-1:0] lk_side   [NLINK];
  logic [EDGEW-1:0] lk_edge   [NLINK];
  logic [TGTW-1:0]  lk_tgt    [NLINK];
  int               total;
  logic [10:0]      tri_count_cfg;
  logic [3:0]       special_cfg;
  link_result_t     expected_q[$];

  function automatic bit head_special(int t);
    int f;
    f = tri_first[t];
    return f < total && lk_side[f] == special_cfg;
  endfunction

  function automatic void adjust_later(int t, int n, logic [FLW-1:0] delta);
    for (int k = t + 1; k < n; k++) tri_first[k] = tri_first[k] + delta;
  endfunction

  function automatic link_result_t apply_request(cmd_t c, int idx, logic [FLW-1:0] fl,
      logic [CNTW-1:0] lc, logic [SIDEW-1:0] sd, logic [EDGEW-1:0] ed, logic [TGTW-1:0] tg);
    link_result_t r;
    int n;
    int f;
    r = '0;
    r.st = ST_OK;
    n = (tri_count_cfg > NTRI) ? NTRI : int'(tri_count_cfg);
    case (c)
      CMD_LOAD_TRI: begin
        if (idx >= NTRI) r.st = ST_BAD_INDEX;
        else begin
          tri_first[idx] = fl;
          tri_cnt[idx] = lc;
        end
      end
      CMD_APPEND: begin
        if (total >= NLINK) r.st = ST_FULL;
        else begin
          lk_side[total] = sd;
          lk_edge[total] = ed;
          lk_tgt[total] = tg;
          total++;
        end
      end
      CMD_ADD: begin
        if (idx >= n) r.st = ST_BAD_INDEX;
        else begin
          f = tri_first[idx];
          if (tri_cnt[idx] != 0 && head_special(idx)) r.st = ST_EXISTS;
          else if (f > total) r.st = ST_BAD_INDEX;
          else if (tri_cnt[idx] == CNT_MAX) r.st = ST_OVERFLOW;
          else if (total >= NLINK) r.st = ST_FULL;
          else begin
            for (int i = total; i > f; i--) begin
              lk_side[i] = lk_side[i-1];
              lk_edge[i] = lk_edge[i-1];
              lk_tgt[i] = lk_tgt[i-1];
            end
            lk_side[f] = special_cfg;
            lk_edge[f] = '0;
            lk_tgt[f] = tg;
            total++;
            tri_cnt[idx] = tri_cnt[idx] + 1;
            adjust_later(idx, n, 12'd1);
          end
        end
      end
      CMD_UPDATE: begin
        if (idx >= n) r.st = ST_BAD_INDEX;
        else if (!head_special(idx)) r.st = ST_NO_LINK;
        else lk_tgt[tri_first[idx]] = tg;
      end
      CMD_REMOVE: begin
        if (idx >= n) r.st = ST_BAD_INDEX;
        else if (tri_cnt[idx] == 0 || !head_special(idx)) r.st = ST_NO_LINK;
        else begin
          f = tri_first[idx];
          for (int i = f; i + 1 < total; i++) begin
            lk_side[i] = lk_side[i+1];
            lk_edge[i] = lk_edge[i+1];
            lk_tgt[i] = lk_tgt[i+1];
          end
          total--;
          tri_cnt[idx] = tri_cnt[idx] - 1;
          adjust_later(idx, n, 12'hFFF);
        end
      end
      CMD_READ_TRI: begin
        if (idx >= NTRI) r.st = ST_BAD_INDEX;
        else begin
          r.fl = tri_first[idx];
          r.lc = tri_cnt[idx];
        end
      end
      CMD_READ_LINK: begin
        if (idx >= total) r.st = ST_BAD_INDEX;
        else begin
          r.sd = lk_side[idx];
          r.ed = lk_edge[idx];
          r.tg = lk_tgt[idx];
        end
      end
      default: total = 0;
    endcase
    r.tot = total[TOTW-1:0];
    return r;
  endfunction

  function automatic void check_field(string name, int e, int a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
      errors++;
    end
  endfunction

  initial begin
    errors = 0;
    pending = 0;
    total = 0;
    tri_count_cfg = '0;
    special_cfg = 4'd15;
    for (int i = 0; i < NTRI; i++) begin
      tri_first[i] = '0;
      tri_cnt[i] = '0;
    end
  end

  always @(posedge clk) begin
    link_result_t e;
    if (rst) begin
      total = 0;
      tri_count_cfg = '0;
      special_cfg = 4'd15;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_TRI_COUNT) tri_count_cfg = pwdata[10:0];
        else if (paddr == ADDR_SPECIAL_SIDE) special_cfg = pwdata[3:0];
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, status %0d", $time, status);
          errors++;
        end else begin
          e = expected_q.pop_front();
          check_field("status", e.st, status);
          check_field("first_link", e.fl, first_link_out);
          check_field("link_count", e.lc, link_count_out);
          check_field("side", e.sd, side_out);
          check_field("edge", e.ed, edge_out);
          check_field("target", e.tg, target_out);
          check_field("total_links", e.tot, total_links_out);
        end
      end
      if (in_valid && !in_stall)
        expected_q.insert(expected_q.size(),
                          apply_request(cmd_t'(cmd), index, first_link_in, link_count_in,
                                        side_in, edge_in, target_in));
    end
    pending = expected_q.size();
  end

endmodule

>>> verif/tb_top.sv
module tb_top;
  import pltir_pkg::*;

  localparam int ADDR_TRI_COUNT    = 0;
  localparam int ADDR_SPECIAL_SIDE = 4;
  localparam int CYCLE_LIMIT       = 2000000;

  logic             clk = 0;
  logic             rst = 1;
  logic             psel = 0, penable = 0, pwrite = 0;
  logic [2:0]       paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;
  logic             in_valid = 0;
  logic             in_stall;
  logic [2:0]       cmd = '0;
  logic [IDXW-1:0]  index = '0;
  logic [FLW-1:0]   first_link_in = '0;
  logic [CNTW-1:0]  link_count_in = '0;
  logic [SIDEW-1:0] side_in = '0;
  logic [EDGEW-1:0] edge_in = '0;
  logic [TGTW-1:0]  target_in = '0;
  logic             out_valid;
  logic             out_stall = 0;
  logic [2:0]       status;
  logic [FLW-1:0]   first_link_out;
  logic [CNTW-1:0]  link_count_out;
  logic [SIDEW-1:0] side_out;
  logic [EDGEW-1:0] edge_out;
  logic [TGTW-1:0]  target_out;
  logic [TOTW-1:0]  total_links_out;

  int pending, errors;
  int cycles = 0;
  int hold_cnt = 0;
  bit steady = 0;
  bit long_hold = 0;
  bit loaded [1024];

  always #5 clk = ~clk;

  packed_link_table_insert_remove_unit dut (.*);

  link_table_checker #(
    .ADDR_TRI_COUNT(ADDR_TRI_COUNT), .ADDR_SPECIAL_SIDE(ADDR_SPECIAL_SIDE)
  ) checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: random stalls, none while steady, one long hold-off on request
  always @(posedge clk) begin
    if (long_hold && hold_cnt < 400) begin
      out_stall <= 1;
      hold_cnt <= hold_cnt + 1;
    end else if (steady) out_stall <= 0;
    else out_stall <= ($urandom_range(0, 99) < 29);
  end

  task automatic reg_write(int addr, int value);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= 3'(addr);
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  task automatic settle();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send(cmd_t c, int idx, int fl = 0, int lc = 0, int sd = 0, int ed = 0,
                      int tg = 0);
    while (!steady && $urandom_range(0, 99) < 29) begin
      in_valid <= 0;
      @(posedge clk);
    end
    cmd <= c;
    index <= IDXW'(idx);
    first_link_in <= FLW'(fl);
    link_count_in <= CNTW'(lc);
    side_in <= SIDEW'(sd);
    edge_in <= EDGEW'(ed);
    target_in <= TGTW'(tg);
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (c == CMD_LOAD_TRI && idx < 1024) loaded[idx] = 1;
  endtask

  function automatic int pick_loaded();
    int t;
    t = $urandom_range(0, 1023);
    while (!loaded[t]) t = $urandom_range(0, 1023);
    return t;
  endfunction

  initial begin
    int cur, n, r, t;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // no triangles in use
    reg_write(ADDR_TRI_COUNT, 0);
    reg_write(ADDR_SPECIAL_SIDE, 15);
    send(CMD_CLEAR, 0);
    send(CMD_ADD, 0, 0, 0, 0, 0, 1);
    send(CMD_READ_LINK, 4095);
    send(CMD_READ_TRI, 4095);
    settle();

    reg_write(ADDR_TRI_COUNT, 4);
    send(CMD_APPEND, 0, 0, 0, 3, 3, 1023);
    send(CMD_APPEND, 0, 0, 0, 0, 0, 0);
    send(CMD_APPEND, 0, 0, 0, 15, 1, 5);
    send(CMD_LOAD_TRI, 0, 0, 2);
    send(CMD_LOAD_TRI, 1, 2, 0);
    send(CMD_LOAD_TRI, 2, 2, 1);
    send(CMD_LOAD_TRI, 3, 3, 15);
    send(CMD_ADD, 0, 0, 0, 0, 0, 1023);
    send(CMD_ADD, 0, 0, 0, 0, 0, 7);
    send(CMD_UPDATE, 0, 0, 0, 0, 0, 1023);
    send(CMD_READ_LINK, 0);
    send(CMD_REMOVE, 0);
    send(CMD_REMOVE, 1);
    send(CMD_UPDATE, 1, 0, 0, 0, 0, 0);
    send(CMD_ADD, 2, 0, 0, 0, 0, 3);
    send(CMD_ADD, 3, 0, 0, 0, 0, 3);
    send(CMD_LOAD_TRI, 1, 4095, 0);
    send(CMD_ADD, 1, 0, 0, 0, 0, 3);
    send(CMD_ADD, 4, 0, 0, 0, 0, 3);
    send(CMD_READ_TRI, 3);
    send(CMD_READ_LINK, 2);
    send(CMD_UPDATE, 3, 0, 0, 0, 0, 9);
    settle();

    // random: sixteen triangles with contiguous runs
    reg_write(ADDR_TRI_COUNT, 16);
    reg_write(ADDR_SPECIAL_SIDE, 9);
    send(CMD_CLEAR, 0);
    cur = 0;
    for (int i = 0; i < 16; i++) begin
      n = $urandom_range(0, 3);
      send(CMD_LOAD_TRI, i, cur, n);
      for (int j = 0; j < n; j++) begin
        r = (j == 0 && $urandom_range(0, 2) == 0) ? 9 : $urandom_range(0, 15);
        if (j != 0 && r == 9) r = 10;
        send(CMD_APPEND, 0, 0, 0, r, $urandom_range(0, 3), $urandom_range(0, 1023));
      end
      cur += n;
    end
    for (int k = 0; k < 30; k++) begin
      if (k == 8) long_hold = 1;
      if (k == 16) settle();
      steady = (k >= 20 && k < 28);
      r = $urandom_range(0, 99);
      t = $urandom_range(0, 15);
      if (r < 30) send(CMD_ADD, t, 0, 0, 0, 0, $urandom_range(0, 1023));
      else if (r < 45) send(CMD_UPDATE, t, 0, 0, 0, 0, $urandom_range(0, 1023));
      else if (r < 68) send(CMD_REMOVE, t);
      else if (r < 75) send(CMD_READ_TRI, $urandom_range(0, 1) ? pick_loaded()
                                                 : $urandom_range(1024, 4095));
      else if (r < 85) send(CMD_READ_LINK, $urandom_range(0, 3) ? $urandom_range(0, 60)
                                                   : $urandom_range(0, 4095));
      else if (r < 90) send(CMD_APPEND, 0, 0, 0, $urandom_range(0, 15), $urandom_range(0, 3),
                            $urandom_range(0, 1023));
      else if (r < 95) send(CMD_LOAD_TRI, t, $urandom_range(0, 1) ? $urandom_range(0, 40)
                            : $urandom_range(0, 4095), $urandom_range(0, 15));
      else if (r < 97) send(CMD_LOAD_TRI, $urandom_range(1024, 4095), $urandom_range(0, 4095),
                            $urandom_range(0, 15));
      else send(CMD_ADD, $urandom_range(16, 4095), 0, 0, 0, 0, $urandom_range(0, 1023));
    end
    steady = 0;
    settle();

    // top of the triangle range
    reg_write(ADDR_TRI_COUNT, 1024);
    reg_write(ADDR_SPECIAL_SIDE, 0);
    send(CMD_CLEAR, 0);
    send(CMD_APPEND, 0, 0, 0, 5, 2, 100);
    send(CMD_LOAD_TRI, 1023, 0, 0);
    send(CMD_ADD, 1023, 0, 0, 0, 0, 512);
    send(CMD_UPDATE, 1023, 0, 0, 0, 0, 777);
    send(CMD_READ_LINK, 0);
    send(CMD_REMOVE, 1023);
    send(CMD_ADD, 2000, 0, 0, 0, 0, 1);
    send(CMD_READ_TRI, 1023);
    settle();

    reg_write(ADDR_TRI_COUNT, 2047);
    send(CMD_ADD, 1500, 0, 0, 0, 0, 1);
    send(CMD_ADD, 1023, 0, 0, 0, 0, 2);
    send(CMD_REMOVE, 1023);
    send(CMD_CLEAR, 0);
    send(CMD_LOAD_TRI, 1023, 0, 0);
    send(CMD_APPEND, 0, 0, 0, 1, 1, 1);
    send(CMD_ADD, 1023, 0, 0, 0, 0, 3);
    send(CMD_READ_LINK, 4095);
    send(CMD_CLEAR, 0);
    settle();

    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/pltir_pkg.sv
rtl/pltir_ram.sv
rtl/pltir_ctrl.sv
rtl/pltir_dp.sv
rtl/packed_link_table_insert_remove_unit.sv
verif/link_table_checker.sv
verif/tb_top.sv
